[hdl/ttrc_pkg.sv]
`default_nettype none

package ttrc_pkg;

   localparam int unsigned TERM_WIDTH  = 16;
   localparam int unsigned INDEX_WIDTH = 8;
   localparam int unsigned BYTE_WIDTH  = 8;

   typedef logic [TERM_WIDTH-1:0]  term_type;
   typedef logic [INDEX_WIDTH-1:0] index_type;
   typedef logic [BYTE_WIDTH-1:0]  byte_type;

   // Fold modulus; 2^16 is congruent to 1 under it
   localparam term_type  MODULUS      = 16'hFFFF;
   localparam index_type A_STEP       = 8'd17;
   localparam index_type B_STEP       = 8'd31;
   localparam term_type  FIRST_OFFSET = 16'd7;
   localparam term_type  TERM_ONE     = 16'd1;

endpackage

`default_nettype wire

[hdl/ttrc_term.sv]
`default_nettype none

module ttrc_term (
   input  wire ttrc_pkg::byte_type  data_byte,
   input  wire ttrc_pkg::index_type byte_index,
   input  wire ttrc_pkg::term_type  current_term,
   input  wire ttrc_pkg::term_type  previous_term,
   output ttrc_pkg::term_type       next_term
);

   logic [15:0] a_prod;
   logic [15:0] b_prod;
   logic [7:0]  coef_a;
   logic [7:0]  coef_b;
   logic [8:0]  mult_a;
   logic [24:0] x_full;
   logic [23:0] y_full;
   logic [16:0] x_sum;
   logic [16:0] y_sum;
   logic [15:0] x_mod;
   logic [15:0] y_mod;
   logic        negative;
   logic [17:0] diff;
   logic [17:0] diff_fix;

   // Index coefficients, kept to their low 8 bits
   assign a_prod = 16'(byte_index) * 16'(ttrc_pkg::A_STEP);
   assign b_prod = 16'(byte_index) * 16'(ttrc_pkg::B_STEP);
   assign coef_a = a_prod[7:0];
   assign coef_b = b_prod[7:0];

   // Two products side by side
   assign mult_a = 9'(data_byte) + 9'(coef_a);
   assign x_full = 25'(mult_a) * 25'(current_term);
   assign y_full = 24'(coef_b) * 24'(previous_term);

   // Wrapping subtraction of the full products adds one when it goes negative
   assign negative = x_full < 25'(y_full);

   // Fold each product: high half plus low half, then one correction
   assign x_sum = 17'(x_full[24:16]) + 17'(x_full[15:0]);
   assign y_sum = 17'(y_full[23:16]) + 17'(y_full[15:0]);
   assign x_mod = (x_sum >= 17'(ttrc_pkg::MODULUS)) ?
                  16'(x_sum - 17'(ttrc_pkg::MODULUS)) : x_sum[15:0];
   assign y_mod = (y_sum >= 17'(ttrc_pkg::MODULUS)) ?
                  16'(y_sum - 17'(ttrc_pkg::MODULUS)) : y_sum[15:0];

   // Difference of residues plus borrow fix, brought back into range
   assign diff = 18'(x_mod) + 18'(negative) - 18'(y_mod);

   always_comb begin
      if (diff[17]) begin
         diff_fix = diff + 18'(ttrc_pkg::MODULUS);
      end else if (diff >= 18'(ttrc_pkg::MODULUS)) begin
         diff_fix = diff - 18'(ttrc_pkg::MODULUS);
      end else begin
         diff_fix = diff;
      end
   end

   assign next_term = diff_fix[15:0];

endmodule

`default_nettype wire

[hdl/three_term_recurrence_checksum_unit.sv]
// Three-term recurrence checksum over a byte stream.
// Input channel req_*: one message byte per beat, req_tlast on the final
// byte of each message. Output channel rsp_*: one 16-bit checksum beat per
// message, sent after its last byte.
// Each accepted byte lands in an input register; from there the recurrence
// step (two small multiplies and a fold modulo 65535) updates the term
// registers and, on a last byte, loads the result register.
// Throughput: one byte per cycle unless a last byte waits on a pending result.
// When rsp_tready is low a pending checksum holds in the result register;
// non-final bytes keep flowing, and a further last byte waits in the input
// register, which then drops req_tready until the result is taken.
// Reset (synchronous, active high) empties both registers and returns the
// block to waiting for the first byte of a message.
`default_nettype none

module three_term_recurrence_checksum_unit (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,   // [7:0] data_byte
   input  wire        req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [15:0] rsp_tdata   // [15:0] checksum
);

   logic                 s1_valid_ff;
   logic                 s1_last_ff;
   ttrc_pkg::byte_type   s1_byte_ff;
   logic                 s1_go;
   logic                 out_free;

   logic                 in_message_ff;
   logic                 in_message_in;
   ttrc_pkg::index_type  byte_index_ff;
   ttrc_pkg::index_type  byte_index_in;
   ttrc_pkg::term_type   current_term_ff;
   ttrc_pkg::term_type   current_term_in;
   ttrc_pkg::term_type   previous_term_ff;
   ttrc_pkg::term_type   previous_term_in;
   ttrc_pkg::term_type   step_term;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   ttrc_pkg::term_type   rsp_data_ff;

   // Handshake: input register drains unless a last byte meets a full output
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_go      = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_tready = !s1_valid_ff || s1_go;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
   end

   // Recurrence step
   ttrc_term u_term (
      .data_byte     (s1_byte_ff),
      .byte_index    (byte_index_ff),
      .current_term  (current_term_ff),
      .previous_term (previous_term_ff),
      .next_term     (step_term)
   );

   // Next state: seed on first byte, advance on later ones, idle after last
   always_comb begin
      in_message_in    = in_message_ff;
      byte_index_in    = byte_index_ff;
      current_term_in  = current_term_ff;
      previous_term_in = previous_term_ff;
      if (s1_go) begin
         if (!in_message_ff) begin
            previous_term_in = ttrc_pkg::TERM_ONE;
            current_term_in  = 16'(s1_byte_ff) + ttrc_pkg::FIRST_OFFSET;
            byte_index_in    = 8'd1;
         end else begin
            previous_term_in = current_term_ff;
            current_term_in  = step_term;
            byte_index_in    = byte_index_ff + 8'd1;
         end
         in_message_in = 1'b1;
         if (s1_last_ff) begin
            in_message_in    = 1'b0;
            byte_index_in    = '0;
            previous_term_in = ttrc_pkg::TERM_ONE;
            current_term_in  = ttrc_pkg::TERM_ONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_message_ff    <= 1'b0;
         byte_index_ff    <= '0;
         current_term_ff  <= ttrc_pkg::TERM_ONE;
         previous_term_ff <= ttrc_pkg::TERM_ONE;
      end else begin
         in_message_ff    <= in_message_in;
         byte_index_ff    <= byte_index_in;
         current_term_ff  <= current_term_in;
         previous_term_ff <= previous_term_in;
      end
   end

   // Result register: load on a last byte, hold until taken
   always_comb begin
      if (s1_go && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_last_ff) begin
         rsp_data_ff <= in_message_ff ? step_term
                                      : 16'(s1_byte_ff) + ttrc_pkg::FIRST_OFFSET;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // A new result only follows a last byte leaving the input register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_last_ff))
      else $error("result without a last byte");

   // Idle between messages means a cleared index
   assert property (@(posedge clock) disable iff (reset)
      !in_message_ff |-> byte_index_ff == '0)
      else $error("index not cleared between messages");

   // Terms stay reduced below the modulus
   assert property (@(posedge clock) disable iff (reset)
      current_term_ff != ttrc_pkg::MODULUS && previous_term_ff != ttrc_pkg::MODULUS)
      else $error("term out of range");

   // A blocked last byte stalls the input side
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input taken while last byte blocked");
`endif

endmodule

`default_nettype wire

[bench/three_term_recurrence_checksum_unit_tb.sv]
`default_nettype none

module three_term_recurrence_checksum_unit_tb;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned TARGET_BYTES = 1550;
   localparam int unsigned DRAIN_CYCLES = 8;

   typedef struct {
      ttrc_pkg::byte_type data;
      bit                 last;
      bit                 drain;   // hold this beat back until every checksum is out
   } byte_beat_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   byte_beat_type      pending_beats[$];
   ttrc_pkg::term_type checksums_due[$];
   byte_beat_type      next_beat;

   // Running copy of the block's recurrence state
   ttrc_pkg::term_type  prev_term;
   ttrc_pkg::term_type  cur_term;
   ttrc_pkg::index_type byte_pos;
   bit                  mid_message;

   int unsigned        mismatches;
   int unsigned        cycle_count;
   int unsigned        burst_left;
   int unsigned        gap_left;
   int unsigned        stall_left;
   int unsigned        phase_cycles;
   bit                 calm_phase;
   ttrc_pkg::term_type want_sum;

   three_term_recurrence_checksum_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // One step of the recurrence; a negative difference wraps as in 64-bit math
   function automatic ttrc_pkg::term_type recurrence_step(ttrc_pkg::byte_type d,
                                                          ttrc_pkg::index_type i,
                                                          ttrc_pkg::term_type cur,
                                                          ttrc_pkg::term_type prev);
      ttrc_pkg::index_type a;
      ttrc_pkg::index_type b;
      longint unsigned     x;
      longint unsigned     y;
      longint unsigned     r;
      a = i * ttrc_pkg::A_STEP;
      b = i * ttrc_pkg::B_STEP;
      x = (longint'(d) + longint'(a)) * longint'(cur);
      y = longint'(b) * longint'(prev);
      if (x >= y) begin
         return ttrc_pkg::term_type'((x - y) % longint'(ttrc_pkg::MODULUS));
      end
      r = (y - x) % longint'(ttrc_pkg::MODULUS);
      return ttrc_pkg::term_type'((64'd65536 - r) % longint'(ttrc_pkg::MODULUS));
   endfunction

   // Advance the running state by one accepted byte; queue a checksum on the last one
   task automatic absorb_byte(ttrc_pkg::byte_type d, bit last);
      ttrc_pkg::term_type t;
      if (!mid_message) begin
         prev_term   = ttrc_pkg::TERM_ONE;
         cur_term    = ttrc_pkg::term_type'(d) + ttrc_pkg::FIRST_OFFSET;
         byte_pos    = 8'd1;
         mid_message = 1'b1;
      end else begin
         t         = recurrence_step(d, byte_pos, cur_term, prev_term);
         prev_term = cur_term;
         cur_term  = t;
         byte_pos  = byte_pos + 8'd1;
      end
      if (last) begin
         checksums_due.push_back(cur_term);
         prev_term   = ttrc_pkg::TERM_ONE;
         cur_term    = ttrc_pkg::TERM_ONE;
         byte_pos    = '0;
         mid_message = 1'b0;
      end
   endtask

   task automatic push_beat(ttrc_pkg::byte_type d, bit last, bit drain);
      byte_beat_type b;
      b.data  = d;
      b.last  = last;
      b.drain = drain;
      pending_beats.push_back(b);
   endtask

   // Driver: bursts of beats with random gaps, honoring drain marks
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left != 0) begin
            gap_left = gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_beats.size() == 0 ||
                      (pending_beats[0].drain &&
                       (req_tvalid || checksums_due.size() != 0))) begin
            req_tvalid <= 1'b0;
         end else begin
            next_beat = pending_beats.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_beat.data;
            req_tlast  <= next_beat.last;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
            end else begin
               burst_left = burst_left - 1;
            end
         end
      end
   end

   // Receiver: calm stretches alternate with stretches of random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left   = 0;
         phase_cycles = 0;
         calm_phase   = 1'b1;
      end else begin
         phase_cycles = phase_cycles + 1;
         if (phase_cycles >= 400) begin
            phase_cycles = 0;
            calm_phase   = ~calm_phase;
         end
         if (stall_left != 0) begin
            stall_left = stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 29);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Monitor: predict from accepted bytes, check each accepted checksum
   always @(posedge clock) begin
      if (reset) begin
         prev_term   = ttrc_pkg::TERM_ONE;
         cur_term    = ttrc_pkg::TERM_ONE;
         byte_pos    = '0;
         mid_message = 1'b0;
         checksums_due.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            absorb_byte(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (checksums_due.size() == 0) begin
               $error("checksum: no beat expected, got %0d", rsp_tdata);
               mismatches = mismatches + 1;
            end else begin
               want_sum = checksums_due.pop_front();
               if (rsp_tdata !== want_sum) begin
                  $error("checksum: expected %0d, got %0d", want_sum, rsp_tdata);
                  mismatches = mismatches + 1;
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("three_term_recurrence_checksum_unit regression: fail");
         $finish;
      end
   end

   initial begin
      int unsigned total;
      int unsigned len;
      int unsigned pick;
      bit          drain;
      mismatches  = 0;
      cycle_count = 0;

      // Single-byte messages at both ends of the byte range
      push_beat(8'd0, 1'b1, 1'b0);
      push_beat(8'd255, 1'b1, 1'b0);
      // Short message whose last step goes negative
      push_beat(8'd252, 1'b0, 1'b0);
      push_beat(8'd237, 1'b0, 1'b0);
      push_beat(8'd0, 1'b1, 1'b0);
      // All-ones and all-zeros bytes
      repeat (3) push_beat(8'd255, 1'b0, 1'b0);
      push_beat(8'd255, 1'b1, 1'b0);
      repeat (2) push_beat(8'd0, 1'b0, 1'b0);
      push_beat(8'd0, 1'b1, 1'b0);
      // Alternating bit patterns
      push_beat(8'hAA, 1'b0, 1'b0);
      push_beat(8'h55, 1'b1, 1'b0);
      push_beat(8'd1, 1'b0, 1'b0);
      push_beat(8'd128, 1'b1, 1'b0);
      total = pending_beats.size();

      // Random messages; the first one is long enough to wrap the byte index
      len = $urandom_range(257, 300);
      drain = 1'b1;
      while (total < TARGET_BYTES) begin
         for (int unsigned k = 0; k < len; k++) begin
            push_beat(ttrc_pkg::byte_type'($urandom_range(0, 255)), k == len - 1,
                      drain && k == 0);
         end
         total = total + len;
         pick  = $urandom_range(0, 59);
         if (pick == 0) begin
            len = $urandom_range(257, 300);
         end else if (pick < 10) begin
            len = 1;
         end else begin
            len = $urandom_range(2, 16);
         end
         drain = ($urandom_range(0, 39) == 0);
      end

      // Let everything through, then wait out the pipeline
      while (pending_beats.size() != 0 || req_tvalid) @(posedge clock);
      while (checksums_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("three_term_recurrence_checksum_unit regression: pass");
      end else begin
         $display("three_term_recurrence_checksum_unit regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
